/* hw/rtl/waveform_peak_pyramid_defines.svh */
// Assertion macros shared by the pyramid RTL.
// Every user module has ports named clock and reset.
`ifndef WAVEFORM_PEAK_PYRAMID_DEFINES_SVH
`define WAVEFORM_PEAK_PYRAMID_DEFINES_SVH

// Same-cycle implication.
`define WPP_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WPP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/wpp_pkg.sv */
package wpp_pkg;

   localparam int LEVEL_BITS  = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

endpackage

/* hw/rtl/wpp_req_if.sv */
interface wpp_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   logic                          final_pair;

   modport source (
      output valid, left_sample, right_sample, final_pair,
      input  ready
   );

   modport sink (
      input  valid, left_sample, right_sample, final_pair,
      output ready
   );
endinterface

/* hw/rtl/wpp_rsp_if.sv */
interface wpp_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                              valid;
   logic                              ready;
   logic [wpp_pkg::LEVEL_BITS-1:0]    level;
   logic signed [SAMPLE_BITS-1:0]     peak_min;
   logic [SAMPLE_BITS-2:0]            peak_max;
   logic                              last_of_run;
   logic                              stream_done;

   modport source (
      output valid, level, peak_min, peak_max, last_of_run, stream_done,
      input  ready
   );

   modport sink (
      input  valid, level, peak_min, peak_max, last_of_run, stream_done,
      output ready
   );
endinterface

/* hw/rtl/wpp_queue.sv */
`include "waveform_peak_pyramid_defines.svh"

module wpp_queue #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          head_data,
   output wpp_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(wpp_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(wpp_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [wpp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data        = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.not_full  = (count_ff != CNT_W'(wpp_pkg::QUEUE_DEPTH));

   `WPP_ASSERT_NOW(a_no_push_when_full, push, count_ff != CNT_W'(wpp_pkg::QUEUE_DEPTH), "queue overflow")
   `WPP_ASSERT_NOW(a_no_pop_when_empty, pop, count_ff != '0, "queue underflow")

endmodule

/* hw/rtl/wpp_front.sv */
module wpp_front #(
   parameter int BASE_GROUP  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   wpp_req_if.sink                   req,
   input  wpp_pkg::queue_status_type q_status,
   output logic                      q_push,
   output logic [2*SAMPLE_BITS-1:0]  q_data
);

   localparam int BASE_W = $clog2(BASE_GROUP);

   logic [BASE_W-1:0]             base_fill_ff;
   logic signed [SAMPLE_BITS-1:0] base_min_ff;
   logic [SAMPLE_BITS-2:0]        base_max_ff;

   logic                          accept;
   logic                          group_end;
   logic signed [SAMPLE_BITS-1:0] pair_min;
   logic signed [SAMPLE_BITS-1:0] pair_max;
   logic signed [SAMPLE_BITS-1:0] min_in;
   logic [SAMPLE_BITS-2:0]        max_in;

   assign req.ready = q_status.not_full;
   assign accept    = req.valid && req.ready;
   assign group_end = (base_fill_ff == BASE_W'(BASE_GROUP - 1)) || req.final_pair;

   always_comb begin
      pair_min = (req.left_sample < req.right_sample) ? req.left_sample : req.right_sample;
      pair_max = (req.left_sample > req.right_sample) ? req.left_sample : req.right_sample;
      min_in   = (pair_min < base_min_ff) ? pair_min : base_min_ff;
      // accumulator max is nonnegative; a negative pair max never wins
      if (!pair_max[SAMPLE_BITS-1] && (pair_max[SAMPLE_BITS-2:0] > base_max_ff)) begin
         max_in = pair_max[SAMPLE_BITS-2:0];
      end else begin
         max_in = base_max_ff;
      end
   end

   assign q_push = accept && group_end;
   assign q_data = {req.final_pair, min_in, max_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         base_fill_ff <= '0;
         base_min_ff  <= '0;
         base_max_ff  <= '0;
      end else if (accept) begin
         if (group_end) begin
            base_fill_ff <= '0;
            base_min_ff  <= '0;
            base_max_ff  <= '0;
         end else begin
            base_fill_ff <= BASE_W'(base_fill_ff + 1'b1);
            base_min_ff  <= min_in;
            base_max_ff  <= max_in;
         end
      end
   end

endmodule

/* hw/rtl/wpp_back.sv */
`include "waveform_peak_pyramid_defines.svh"

module wpp_back #(
   parameter int FANOUT       = 8,
   parameter int UPPER_LEVELS = 5,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wpp_pkg::queue_status_type q_status,
   input  logic [2*SAMPLE_BITS-1:0]  q_head,
   output logic                      q_pop,
   wpp_rsp_if.source                 rsp
);

   localparam int LVL_W  = $clog2(UPPER_LEVELS + 1);
   localparam int IDX_W  = (UPPER_LEVELS > 1) ? $clog2(UPPER_LEVELS) : 1;
   localparam int FILL_W = $clog2(FANOUT);

   // upper level k is kept at index k-1
   logic signed [SAMPLE_BITS-1:0] up_min_ff  [UPPER_LEVELS];
   logic [SAMPLE_BITS-2:0]        up_max_ff  [UPPER_LEVELS];
   logic [FILL_W-1:0]             up_fill_ff [UPPER_LEVELS];
   logic [UPPER_LEVELS-1:0]       live_ff;

   logic                          busy_ff;
   logic [LVL_W-1:0]              carry_lvl_ff;
   logic signed [SAMPLE_BITS-1:0] carry_min_ff;
   logic [SAMPLE_BITS-2:0]        carry_max_ff;
   logic                          carry_fin_ff;

   logic                          rsp_valid_ff;
   logic [LVL_W-1:0]              rsp_lvl_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_min_ff;
   logic [SAMPLE_BITS-2:0]        rsp_max_ff;
   logic                          rsp_last_ff;
   logic                          rsp_done_ff;

   logic                          src_valid;
   logic [LVL_W-1:0]              src_lvl;
   logic signed [SAMPLE_BITS-1:0] src_min;
   logic [SAMPLE_BITS-2:0]        src_max;
   logic                          src_fin;
   logic                          out_free;
   logic                          fire;
   logic                          has_up;
   logic [IDX_W-1:0]              idx;
   logic signed [SAMPLE_BITS-1:0] sel_min;
   logic [SAMPLE_BITS-2:0]        sel_max;
   logic [FILL_W-1:0]             sel_fill;
   logic                          sel_live;
   logic signed [SAMPLE_BITS-1:0] fold_min;
   logic [SAMPLE_BITS-2:0]        fold_max;
   logic                          cont;

   always_comb begin
      if (busy_ff) begin
         src_valid = 1'b1;
         src_lvl   = carry_lvl_ff;
         src_min   = carry_min_ff;
         src_max   = carry_max_ff;
         src_fin   = carry_fin_ff;
      end else begin
         src_valid = q_status.not_empty;
         src_lvl   = '0;
         src_min   = q_head[2*SAMPLE_BITS-2:SAMPLE_BITS-1];
         src_max   = q_head[SAMPLE_BITS-2:0];
         src_fin   = q_head[2*SAMPLE_BITS-1];
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign fire     = src_valid && out_free;
   assign q_pop    = fire && !busy_ff;
   assign has_up   = (src_lvl < LVL_W'(UPPER_LEVELS));
   assign idx      = src_lvl[IDX_W-1:0];

   always_comb begin
      sel_min  = '0;
      sel_max  = '0;
      sel_fill = '0;
      sel_live = 1'b0;
      if (has_up) begin
         sel_min  = up_min_ff[idx];
         sel_max  = up_max_ff[idx];
         sel_fill = up_fill_ff[idx];
         sel_live = live_ff[idx];
      end
      fold_min = (src_min < sel_min) ? src_min : sel_min;
      fold_max = (src_max > sel_max) ? src_max : sel_max;
      // climb when the parent group fills, or during a flush when the parent
      // is live (it now holds at least this entry)
      cont = has_up && ((sel_fill == FILL_W'(FANOUT - 1)) || (src_fin && sel_live));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         live_ff      <= '0;
         for (int k = 0; k < UPPER_LEVELS; k++) begin
            up_min_ff[k]  <= '0;
            up_max_ff[k]  <= '0;
            up_fill_ff[k] <= '0;
         end
      end else begin
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire) begin
            busy_ff <= cont;
            // end of a flush: the whole pyramid starts over
            if (src_fin && !cont) begin
               live_ff <= '0;
               for (int k = 0; k < UPPER_LEVELS; k++) begin
                  up_min_ff[k]  <= '0;
                  up_max_ff[k]  <= '0;
                  up_fill_ff[k] <= '0;
               end
            end else if (has_up) begin
               if (cont) begin
                  up_min_ff[idx]  <= '0;
                  up_max_ff[idx]  <= '0;
                  up_fill_ff[idx] <= '0;
                  live_ff[idx]    <= 1'b1;
               end else begin
                  up_min_ff[idx]  <= fold_min;
                  up_max_ff[idx]  <= fold_max;
                  up_fill_ff[idx] <= FILL_W'(sel_fill + 1'b1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_lvl_ff  <= src_lvl;
         rsp_min_ff  <= src_min;
         rsp_max_ff  <= src_max;
         rsp_last_ff <= !cont;
         rsp_done_ff <= src_fin && !cont;
      end
      if (fire && cont) begin
         carry_lvl_ff <= LVL_W'(src_lvl + 1'b1);
         carry_min_ff <= fold_min;
         carry_max_ff <= fold_max;
         carry_fin_ff <= src_fin;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.level       = wpp_pkg::LEVEL_BITS'(rsp_lvl_ff);
   assign rsp.peak_min    = rsp_min_ff;
   assign rsp.peak_max    = rsp_max_ff;
   assign rsp.last_of_run = rsp_last_ff;
   assign rsp.stream_done = rsp_done_ff;

   `WPP_ASSERT_NOW(a_done_ends_run, rsp_valid_ff && rsp_done_ff, rsp_last_ff, "stream_done without last_of_run")
   `WPP_ASSERT_NOW(a_carry_above_base, busy_ff, carry_lvl_ff != '0, "carry at base level")
   `WPP_ASSERT_NEXT(a_flush_clears_live, fire && src_fin && !cont, live_ff == '0, "levels live after flush")

endmodule

/* hw/rtl/waveform_peak_pyramid.sv */
// Channel   Dir   Payload                                             Accepted when
// req       in    left_sample, right_sample, final_pair               req.valid && req.ready
// rsp       out   level, peak_min, peak_max, last_of_run, stream_done rsp.valid && rsp.ready
//
// One sample pair is accepted per cycle while the 4-entry group queue has room.
// The result side emits one pyramid entry per cycle while rsp is not stalled; a group plus
// its upward cascade or flush gives up to UPPER_LEVELS+1 entries.
// Sustained input rate is one pair per cycle unless entries arrive faster than
// the result side drains them, in which case req.ready drops while the queue is full.
// Synchronous reset clears pointers, counts, flags and accumulators; no clearing pass.
// A stalled rsp holds its entry in the output register and halts the cascade and queue pops.
module waveform_peak_pyramid #(
   parameter int BASE_GROUP   = 32,
   parameter int FANOUT       = 8,
   parameter int UPPER_LEVELS = 5,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   wpp_req_if.sink   req,
   wpp_rsp_if.source rsp
);

   wpp_pkg::queue_status_type q_status;
   logic                      q_push;
   logic                      q_pop;
   logic [2*SAMPLE_BITS-1:0]  q_data;
   logic [2*SAMPLE_BITS-1:0]  q_head;

   wpp_front #(
      .BASE_GROUP  (BASE_GROUP),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   wpp_queue #(
      .WIDTH (2*SAMPLE_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head_data (q_head),
      .status    (q_status)
   );

   wpp_back #(
      .FANOUT       (FANOUT),
      .UPPER_LEVELS (UPPER_LEVELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp      (rsp)
   );

endmodule

/* tb/tb_top.sv */
module tb_top;

   localparam int BASE_GROUP  = 32;
   localparam int FANOUT      = 8;
   localparam int TOP_LEVEL   = 5;
   localparam int SB          = 16;
   localparam int LONG_HOLD   = 400;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE      = 40;
   localparam int HOLD_CLIPS  = 6;
   // one full level-1 entry, then a single pair that flushes through the live level
   localparam int LAST_CLIP   = BASE_GROUP * FANOUT + 1;

   typedef struct packed {
      logic [wpp_pkg::LEVEL_BITS-1:0] level;
      logic signed [SB-1:0]           peak_min;
      logic [SB-2:0]                  peak_max;
      logic                           last_of_run;
      logic                           stream_done;
   } pyramid_entry_type;

   typedef enum int {
      TONE_FULL,
      TONE_SCALED,
      TONE_POSITIVE,
      TONE_NEGATIVE,
      TONE_RAIL
   } tone_type;

   class peak_scoreboard;
      pyramid_entry_type expected_entries[$];
      pyramid_entry_type step_out[$];
      logic [TOP_LEVEL:0][SB-1:0] floor_acc;
      logic [TOP_LEVEL:0][SB-1:0] crest_acc;
      logic [TOP_LEVEL:0][15:0]   group_count;
      logic [TOP_LEVEL:0]         level_open;
      int unsigned mismatches;
      int unsigned predicted;
      int unsigned checked;

      function new();
         mismatches = 0;
         predicted  = 0;
         checked    = 0;
         clear_pyramid();
      endfunction

      function void clear_pyramid();
         floor_acc   = '0;
         crest_acc   = '0;
         group_count = '0;
         level_open  = '0;
      endfunction

      function void fold(input int unsigned lvl, input logic signed [SB-1:0] lo,
                         input logic signed [SB-1:0] hi);
         logic signed [SB-1:0] cur;
         cur = floor_acc[lvl];
         if (lo < cur) floor_acc[lvl] = lo;
         cur = crest_acc[lvl];
         if (hi > cur) crest_acc[lvl] = hi;
      endfunction

      // emit one entry and carry it up as far as groups complete
      function void cascade(input int unsigned lvl, input logic signed [SB-1:0] lo,
                            input logic signed [SB-1:0] hi);
         pyramid_entry_type e;
         bit climbing;
         climbing = 1;
         while (climbing) begin
            e.level       = wpp_pkg::LEVEL_BITS'(lvl);
            e.peak_min    = lo;
            e.peak_max    = hi[SB-2:0];
            e.last_of_run = 1'b0;
            e.stream_done = 1'b0;
            step_out = {step_out, e};
            predicted++;
            if (lvl == TOP_LEVEL) begin
               climbing = 0;
            end else begin
               lvl++;
               fold(lvl, lo, hi);
               group_count[lvl] = 16'(group_count[lvl] + 1);
               if (group_count[lvl] < FANOUT) begin
                  climbing = 0;
               end else begin
                  group_count[lvl] = '0;
                  level_open[lvl]  = 1'b1;
                  lo = floor_acc[lvl];
                  hi = crest_acc[lvl];
                  floor_acc[lvl] = '0;
                  crest_acc[lvl] = '0;
               end
            end
         end
      endfunction

      function void close_group(input int unsigned lvl);
         logic signed [SB-1:0] lo;
         logic signed [SB-1:0] hi;
         lo = floor_acc[lvl];
         hi = crest_acc[lvl];
         floor_acc[lvl]   = '0;
         crest_acc[lvl]   = '0;
         group_count[lvl] = '0;
         cascade(lvl, lo, hi);
      endfunction

      function void note_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                              input logic fin);
         pyramid_entry_type e;
         int k;
         step_out.delete();
         fold(0, l, l);
         fold(0, r, r);
         group_count[0] = 16'(group_count[0] + 1);
         if (group_count[0] >= BASE_GROUP) close_group(0);
         if (fin) begin
            if (group_count[0] > 0) close_group(0);
            // flush stops at the first level that never completed a group
            for (k = 1; k <= TOP_LEVEL && level_open[k]; k++) begin
               if (group_count[k] > 0) close_group(k);
            end
            if (step_out.size() > 0) begin
               e = step_out[step_out.size()-1];
               e.stream_done = 1'b1;
               step_out[step_out.size()-1] = e;
            end
            clear_pyramid();
         end
         if (step_out.size() > 0) begin
            e = step_out[step_out.size()-1];
            e.last_of_run = 1'b1;
            step_out[step_out.size()-1] = e;
         end
         expected_entries = {expected_entries, step_out};
      endfunction

      task flag_mismatch(input string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_entry(input pyramid_entry_type got);
         pyramid_entry_type want;
         if (expected_entries.size() == 0) begin
            flag_mismatch($sformatf("unexpected entry level %0d min %0d max %0d",
                                    got.level, got.peak_min, got.peak_max));
         end else begin
            want = expected_entries.pop_front();
            checked++;
            if (got.level !== want.level)
               flag_mismatch($sformatf("entry %0d level %0d, want %0d",
                                       checked, got.level, want.level));
            if (got.peak_min !== want.peak_min)
               flag_mismatch($sformatf("entry %0d peak_min %0d, want %0d",
                                       checked, got.peak_min, want.peak_min));
            if (got.peak_max !== want.peak_max)
               flag_mismatch($sformatf("entry %0d peak_max %0d, want %0d",
                                       checked, got.peak_max, want.peak_max));
            if (got.last_of_run !== want.last_of_run)
               flag_mismatch($sformatf("entry %0d last_of_run %b, want %b",
                                       checked, got.last_of_run, want.last_of_run));
            if (got.stream_done !== want.stream_done)
               flag_mismatch($sformatf("entry %0d stream_done %b, want %b",
                                       checked, got.stream_done, want.stream_done));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   wpp_req_if #(.SAMPLE_BITS(SB)) req_bus ();
   wpp_rsp_if #(.SAMPLE_BITS(SB)) rsp_bus ();

   waveform_peak_pyramid #(
      .BASE_GROUP   (BASE_GROUP),
      .FANOUT       (FANOUT),
      .UPPER_LEVELS (TOP_LEVEL),
      .SAMPLE_BITS  (SB)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   peak_scoreboard    sb;
   pyramid_entry_type seen_entry;
   tone_type          tone;
   int unsigned       tone_shift;
   logic              idle_on;
   int unsigned       holds_asked = 0;
   int unsigned       holds_taken = 0;
   int unsigned       hold_left   = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       pairs_sent  = 0;
   int unsigned       clips_sent  = 0;
   int unsigned       level_hits [0:7];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: check, then decide ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_entry.level       = rsp_bus.level;
         seen_entry.peak_min    = rsp_bus.peak_min;
         seen_entry.peak_max    = rsp_bus.peak_max;
         seen_entry.last_of_run = rsp_bus.last_of_run;
         seen_entry.stream_done = rsp_bus.stream_done;
         sb.check_entry(seen_entry);
         level_hits[rsp_bus.level]++;
      end
      if (holds_taken != holds_asked) begin
         holds_taken   <= holds_asked;
         hold_left     <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         hold_left     <= $urandom_range(0, 5);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d entries outstanding",
                  quiet_cycles, sb.expected_entries.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void retune();
      tone       = tone_type'($urandom_range(0, 4));
      tone_shift = $urandom_range(0, SB - 1);
   endfunction

   function automatic logic signed [SB-1:0] pick_sample();
      logic signed [SB-1:0] raw;
      raw = SB'($urandom);
      case (tone)
         TONE_SCALED:   raw = raw >>> tone_shift;
         TONE_POSITIVE: raw = {1'b0, raw[SB-2:0]} >> tone_shift;
         TONE_NEGATIVE: raw = ~({1'b0, raw[SB-2:0]} >> tone_shift);
         TONE_RAIL:     raw = raw[0] ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
         default: ;
      endcase
      return raw;
   endfunction

   task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                            input logic fin);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.left_sample  <= l;
      req_bus.right_sample <= r;
      req_bus.final_pair   <= fin;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_pair(l, r, fin);
      pairs_sent++;
      if (fin) clips_sent++;
   endtask

   task automatic send_clip(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 47) == 0) retune();
         send_pair(pick_sample(), pick_sample(), i == len - 1);
      end
   endtask

   // sender stays quiet until every outstanding entry has come back
   task automatic drain_pause();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_entries.size() != 0);
   endtask

   initial begin
      sb = new();
      foreach (level_hits[i]) level_hits[i] = 0;
      reset                = 1'b1;
      idle_on              = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.left_sample  = '0;
      req_bus.right_sample = '0;
      req_bus.final_pair   = 1'b0;
      retune();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // one- to three-pair clips: rails, zero, seed-at-zero on each side
      send_pair(16'sh7fff, 16'sh8000, 1'b1);
      send_pair(16'sh8000, 16'sh7fff, 1'b1);
      send_pair(16'sh0000, 16'sh0000, 1'b1);
      send_pair(16'sd1,    16'sd2,    1'b1);
      send_pair(-16'sd1,   -16'sd2,   1'b1);
      send_pair(16'sh7fff, 16'sh7fff, 1'b0);
      send_pair(16'sh8000, 16'sh8000, 1'b1);
      send_pair(16'shaaaa, 16'sh5555, 1'b0);
      send_pair(16'sh5555, 16'shaaaa, 1'b0);
      send_pair(16'sh0000, 16'sh0000, 1'b1);
      drain_pause();

      // receiver holds off while short clips pile up and the input stalls
      holds_asked <= holds_asked + 1;
      repeat (HOLD_CLIPS) send_clip(1);
      // group that ends exactly on the final pair
      send_clip(BASE_GROUP);
      drain_pause();

      idle_on = 1'b0;
      send_clip(LAST_CLIP);
      req_bus.valid <= 1'b0;

      while (sb.expected_entries.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d pairs in %0d clips, %0d entries checked, with a long output stall",
               pairs_sent, clips_sent, sb.checked);
      $display("entries by level 0..5: %0d %0d %0d %0d %0d %0d", level_hits[0], level_hits[1],
               level_hits[2], level_hits[3], level_hits[4], level_hits[5]);
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
